[rtl/sha256_engine_registers_assert.svh]
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef SHA256_ENGINE_REGISTERS_ASSERT_SVH
`define SHA256_ENGINE_REGISTERS_ASSERT_SVH

`define S256ER_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define S256ER_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/s256er_pkg.sv]
`timescale 1ns / 1ps
package s256er_pkg;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS = 64;

	localparam logic [1:0] ACT_WR_CTRL = 2'd0;
	localparam logic [1:0] ACT_WR_FIFO = 2'd1;
	localparam logic [1:0] ACT_RD_CTRL = 2'd2;
	localparam logic [1:0] ACT_RD_HASH = 2'd3;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_DIGEST [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic init;
		logic start;
		logic round;
		logic ext;
		logic fold;
		logic swap;
	} core_ctl_t;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction
endpackage

[rtl/s256er_req_if.sv]
`timescale 1ns / 1ps
interface s256er_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [4:0]  byte_index;
	logic [31:0] write_value;

	modport source (output valid, action, byte_index, write_value, input ready);
	modport sink (input valid, action, byte_index, write_value, output ready);
endinterface

[rtl/s256er_rsp_if.sv]
`timescale 1ns / 1ps
interface s256er_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        mode_error;

	modport source (output valid, read_data, mode_error, input ready);
	modport sink (input valid, read_data, mode_error, output ready);
endinterface

[rtl/s256er_ram.sv]
`timescale 1ns / 1ps
module s256er_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/s256er_core.sv]
`timescale 1ns / 1ps
module s256er_core #(
	parameter int BLOCK_WORDS = s256er_pkg::BLOCK_WORDS,
	parameter int ROUNDS = s256er_pkg::ROUNDS
) (
	input  logic                      clk,
	input  s256er_pkg::core_ctl_t     ctl,
	input  logic [$clog2(ROUNDS)-1:0] round_idx,
	input  logic [31:0]               ext_word,
	input  logic [2:0]                rd_idx,
	output logic [31:0]               rd_word
);
	logic [31:0] digest_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] w_exp, w_cur, s0, s1, e, a, t1, t2, sig_e, sig_a, ch, maj;

	always_comb begin
		s0 = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
			^ (win_q[1] >> 3);
		s1 = {win_q[BLOCK_WORDS-2][16:0], win_q[BLOCK_WORDS-2][31:17]}
			^ {win_q[BLOCK_WORDS-2][18:0], win_q[BLOCK_WORDS-2][31:19]}
			^ (win_q[BLOCK_WORDS-2] >> 10);
		w_exp = win_q[0] + s0 + win_q[BLOCK_WORDS-7] + s1;
		w_cur = ctl.ext ? ext_word : w_exp;
		e = v_q[4];
		a = v_q[0];
		sig_e = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		sig_a = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		ch = (e & v_q[5]) ^ (~e & v_q[6]);
		maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + sig_e + ch + s256er_pkg::ROUND_K[round_idx] + w_cur;
		t2 = sig_a + maj;
	end

	assign rd_word = digest_q[rd_idx];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) begin
			if (ctl.init) begin
				digest_q[i] <= s256er_pkg::INIT_DIGEST[i];
			end else if (ctl.fold) begin
				digest_q[i] <= digest_q[i] + v_q[i];
			end else if (ctl.swap) begin
				digest_q[i] <= s256er_pkg::swap32(digest_q[i]);
			end
		end
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= digest_q[i];
			end
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (ctl.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BLOCK_WORDS-1] <= w_cur;
		end
	end
endmodule

[rtl/sha256_engine_registers.sv]
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | action, byte_index, write_value
// rsp     | out | read_data, mode_error
// Reads and writes that start no hash answer in the cycle after acceptance.
// A block hash runs a queue RAM prefetch, the rounds (one round a cycle) and a
// digest fold; a finish adds a second block when the queue is nearly full and
// a byte swap step for big-endian output.
// arst_n clears control, counts and handshake state; the digest is set by bit0.
// No word is accepted while hashing or while an answer waits and is stalled.
`include "sha256_engine_registers_assert.svh"
module sha256_engine_registers #(
	parameter int BLOCK_WORDS = s256er_pkg::BLOCK_WORDS,
	parameter int ROUNDS = s256er_pkg::ROUNDS
) (
	input logic clk,
	input logic arst_n,
	s256er_req_if.sink req,
	s256er_rsp_if.source rsp
);
	localparam int AW = $clog2(BLOCK_WORDS);
	localparam int RW = $clog2(ROUNDS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PRE   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_SWAP  = 5'b10000
	} state_t;

	state_t state_q;
	logic [AW:0] q_count_q;
	logic [26:0] msg_q;
	logic irq0_q, be_q, irq1_q;
	logic [1:0] mode_q;
	logic fin_q, second_q;
	logic [AW-1:0] n_q;
	logic [RW-1:0] r_q;
	logic out_valid_q, out_err_q;
	logic [31:0] out_data_q;

	logic acc;
	logic [1:0] new_mode;
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [31:0] ram_rdata, ext_word, bits, rd_word;
	logic [7:0] hash_byte;
	logic fin_req, blk_req, err_go, hash_go, second_go, out_load;
	s256er_pkg::core_ctl_t ctl;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign acc = req.valid && req.ready;
	assign new_mode = req.write_value[5:4];
	assign ram_we = acc && (req.action == s256er_pkg::ACT_WR_FIFO);
	assign ram_raddr = (state_q == ST_ROUND) ? AW'(r_q[AW-1:0] + 1'b1) : '0;
	assign bits = {msg_q, 5'b0};
	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.mode_error = out_err_q;

	assign fin_req = acc && (req.action == s256er_pkg::ACT_WR_CTRL) && req.write_value[1];
	assign blk_req = acc && (req.action == s256er_pkg::ACT_WR_FIFO)
		&& (q_count_q == (AW+1)'(BLOCK_WORDS - 1));
	assign err_go = (fin_req && (new_mode != 2'd0)) || (blk_req && (mode_q != 2'd0));
	assign hash_go = (fin_req && (new_mode == 2'd0)) || (blk_req && (mode_q == 2'd0));
	assign second_go = fin_q && !second_q && (n_q >= AW'(BLOCK_WORDS - 2));
	assign out_load = ((state_q == ST_IDLE) && acc && !hash_go)
		|| ((state_q == ST_FOLD) && !second_go && !(fin_q && be_q))
		|| (state_q == ST_SWAP);

	s256er_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_queue (
		.clk(clk), .we(ram_we), .waddr(q_count_q[AW-1:0]), .wdata(req.write_value),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_comb begin
		if (!fin_q) begin
			ext_word = s256er_pkg::swap32(ram_rdata);
		end else if (second_q) begin
			ext_word = (r_q == RW'(BLOCK_WORDS - 1)) ? bits : '0;
		end else if (r_q < RW'(n_q)) begin
			ext_word = s256er_pkg::swap32(ram_rdata);
		end else if (r_q == RW'(n_q)) begin
			ext_word = s256er_pkg::PAD_WORD;
		end else if (r_q == RW'(BLOCK_WORDS - 1) && n_q < AW'(BLOCK_WORDS - 2)) begin
			ext_word = bits;
		end else begin
			ext_word = '0;
		end
	end

	always_comb begin
		ctl = '0;
		ctl.init = acc && (req.action == s256er_pkg::ACT_WR_CTRL) && req.write_value[0];
		ctl.start = (state_q == ST_PRE);
		ctl.round = (state_q == ST_ROUND);
		ctl.ext = (state_q == ST_ROUND) && (r_q < RW'(BLOCK_WORDS));
		ctl.fold = (state_q == ST_FOLD);
		ctl.swap = (state_q == ST_SWAP);
	end

	s256er_core #(.BLOCK_WORDS(BLOCK_WORDS), .ROUNDS(ROUNDS)) u_core (
		.clk(clk), .ctl(ctl), .round_idx(r_q), .ext_word(ext_word),
		.rd_idx(req.byte_index[4:2]), .rd_word(rd_word)
	);

	always_comb begin
		case (req.byte_index[1:0])
			2'd0: hash_byte = rd_word[7:0];
			2'd1: hash_byte = rd_word[15:8];
			2'd2: hash_byte = rd_word[23:16];
			default: hash_byte = rd_word[31:24];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			q_count_q <= '0;
			msg_q <= '0;
			irq0_q <= 1'b0;
			be_q <= 1'b0;
			irq1_q <= 1'b0;
			mode_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			n_q <= '0;
			r_q <= '0;
			out_valid_q <= 1'b0;
			out_err_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						out_err_q <= err_go;
						unique case (req.action)
							s256er_pkg::ACT_WR_CTRL: begin
								out_data_q <= '0;
								if (req.write_value[0]) begin
									msg_q <= '0;
								end
								irq0_q <= req.write_value[2];
								be_q <= req.write_value[3];
								mode_q <= new_mode;
								irq1_q <= req.write_value[10];
								if (req.write_value[1]) begin
									q_count_q <= '0;
									if (new_mode == 2'd0) begin
										fin_q <= 1'b1;
										second_q <= 1'b0;
										n_q <= q_count_q[AW-1:0];
										state_q <= ST_PRE;
									end
								end
							end
							s256er_pkg::ACT_WR_FIFO: begin
								out_data_q <= '0;
								msg_q <= msg_q + 27'd1;
								if (q_count_q == (AW+1)'(BLOCK_WORDS - 1)) begin
									q_count_q <= '0;
									if (mode_q == 2'd0) begin
										fin_q <= 1'b0;
										second_q <= 1'b0;
										state_q <= ST_PRE;
									end
								end else begin
									q_count_q <= q_count_q + 1'b1;
								end
							end
							s256er_pkg::ACT_RD_CTRL: begin
								out_data_q <= {21'd0, irq1_q, 4'd0, mode_q, be_q, irq0_q, 2'd0};
							end
							default: begin
								out_data_q <= {24'd0, hash_byte};
							end
						endcase
					end
				end
				ST_PRE: begin
					r_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					r_q <= r_q + 1'b1;
					if (r_q == RW'(ROUNDS - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (second_go) begin
						second_q <= 1'b1;
						state_q <= ST_PRE;
					end else if (fin_q && be_q) begin
						state_q <= ST_SWAP;
					end else begin
						out_err_q <= 1'b0;
						out_data_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_SWAP: begin
					out_err_q <= 1'b0;
					out_data_q <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`S256ER_ASSERT(a_ready_idle, req.ready |-> (state_q == ST_IDLE), "ready outside idle")
	`S256ER_ASSERT(a_round_end, (state_q == ST_ROUND && r_q == RW'(ROUNDS - 1)) |=> (state_q == ST_FOLD), "round count overrun")
	`S256ER_ASSERT(a_queue_empty, (state_q == ST_PRE) |-> (q_count_q == '0), "queue not drained at hash start")
	`S256ER_NEVER(a_no_out_busy, out_valid_q && (state_q == ST_ROUND), "answer pending during rounds")
endmodule
